### rtl/core/mmi_pkg.sv
// Shared types and constants of the Montgomery modular inverse core.
// No dependencies; every other file of the core refers to it by scoped names.
package mmi_pkg;

    localparam int WORD_BITS    = 64;
    localparam int NUM_WORDS    = 4;
    localparam int FIELD_BITS   = WORD_BITS * NUM_WORDS;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_MODULUS_WORD0 = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MODULUS_WORD1 = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MODULUS_WORD2 = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MODULUS_WORD3 = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_PREP,
        S_R2,
        S_SETUP,
        S_ZCHK,
        S_AMI,
        S_ACHK,
        S_FIX,
        S_NEG,
        S_HALF,
        S_MSTART,
        S_MSTEP,
        S_MFIX,
        S_CLR,
        S_OUT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_REDUCE,
        OP_R2,
        OP_SETUP,
        OP_AMI,
        OP_FIX,
        OP_NEG,
        OP_HALF,
        OP_MSTART,
        OP_MSTEP,
        OP_MFIX,
        OP_CLR
    } op_t;

    typedef struct packed {
        op_t  op;
        logic ysel;      // Montgomery multiplicand: 0 radix square, 1 operand a
        logic load_out;  // capture the result into the output register
    } cmd_t;

    typedef struct packed {
        logic p_ok;
        logic mode;
        logic v_zero;
        logic u_one;
        logic r_ge_p;
    } status_t;

endpackage

### rtl/core/mmi_if.sv
// Channel interfaces of the Montgomery modular inverse core.
// Depends on mmi_pkg for the word width.
interface mmi_in_if;
    logic                          valid;
    logic                          ready;
    logic                          mode;
    logic [mmi_pkg::WORD_BITS-1:0] a_word0;
    logic [mmi_pkg::WORD_BITS-1:0] a_word1;
    logic [mmi_pkg::WORD_BITS-1:0] a_word2;
    logic [mmi_pkg::WORD_BITS-1:0] a_word3;
    logic [mmi_pkg::WORD_BITS-1:0] b_word0;
    logic [mmi_pkg::WORD_BITS-1:0] b_word1;
    logic [mmi_pkg::WORD_BITS-1:0] b_word2;
    logic [mmi_pkg::WORD_BITS-1:0] b_word3;

    modport source (output valid, mode, a_word0, a_word1, a_word2, a_word3,
                    b_word0, b_word1, b_word2, b_word3, input ready);
    modport sink (input valid, mode, a_word0, a_word1, a_word2, a_word3,
                  b_word0, b_word1, b_word2, b_word3, output ready);
endinterface

interface mmi_out_if;
    logic                          valid;
    logic                          ready;
    logic [mmi_pkg::WORD_BITS-1:0] result_word0;
    logic [mmi_pkg::WORD_BITS-1:0] result_word1;
    logic [mmi_pkg::WORD_BITS-1:0] result_word2;
    logic [mmi_pkg::WORD_BITS-1:0] result_word3;

    modport source (output valid, result_word0, result_word1, result_word2,
                    result_word3, input ready);
    modport sink (input valid, result_word0, result_word1, result_word2,
                  result_word3, output ready);
endinterface

### rtl/core/montgomery_modular_inverse_core.sv
// Top level of the Montgomery modular inverse core: channels, config port,
// sequencer and datapath. Depends on mmi_pkg, mmi_if, mmi_ctrl and mmi_dp.
//
//  channel | dir | handshake       | payload
//  --------+-----+-----------------+-----------------------------------------
//  in_ch   | in  | valid / ready   | mode, a_word0..3, b_word0..3
//  out_ch  | out | valid / ready   | result_word0..3
//  cfg     | in  | cfg_we (no wait)| cfg_index, cfg_data (modulus_word0..3)
//
// Steps per item (M = OPERAND_BITS): operand reduction and then the radix
// square (one shift-subtract per cycle), up to 2M+1 almost-inverse steps,
// repeated subtraction of p from r, up to 2M+1 halvings, then two (mode 0)
// or three (mode 1) bit-serial Montgomery products. A bad modulus or zero
// operand ends early.
// rst_n clears the modulus words and all control state asynchronously.
// A finished result waits in the output register; the next item is taken
// while it waits, and the core stalls only when that register is still full.
module montgomery_modular_inverse_core #(
    parameter int OPERAND_BITS = 256
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [mmi_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [mmi_pkg::WORD_BITS-1:0]     cfg_data,
    mmi_in_if.sink                            in_ch,
    mmi_out_if.source                         out_ch
);

    mmi_pkg::cmd_t                  cmd;
    mmi_pkg::status_t               status;
    logic [mmi_pkg::FIELD_BITS-1:0] in_a, in_b, result;

    // Gather operand words low word first.
    assign in_a = {in_ch.a_word3, in_ch.a_word2, in_ch.a_word1, in_ch.a_word0};
    assign in_b = {in_ch.b_word3, in_ch.b_word2, in_ch.b_word1, in_ch.b_word0};

    mmi_ctrl #(
        .OPERAND_BITS (OPERAND_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_ready (out_ch.ready),
        .out_valid (out_ch.valid),
        .status    (status),
        .cmd       (cmd)
    );

    mmi_dp #(
        .OPERAND_BITS (OPERAND_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_mode   (in_ch.mode),
        .in_a      (in_a),
        .in_b      (in_b),
        .cmd       (cmd),
        .status    (status),
        .result    (result)
    );

    // Split the held result into output words.
    assign out_ch.result_word0 = result[63:0];
    assign out_ch.result_word1 = result[127:64];
    assign out_ch.result_word2 = result[191:128];
    assign out_ch.result_word3 = result[255:192];

endmodule

### rtl/core/mmi_ctrl.sv
// Sequencer of the Montgomery modular inverse core: issues datapath commands.
// Depends on mmi_pkg.
module mmi_ctrl #(
    parameter int OPERAND_BITS = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              out_ready,
    output logic              out_valid,
    input  mmi_pkg::status_t  status,
    output mmi_pkg::cmd_t     cmd
);

    localparam int CW = $clog2(OPERAND_BITS);
    localparam int KW = $clog2(2 * OPERAND_BITS + 2);
    localparam logic [CW-1:0] CNT_LAST = CW'(OPERAND_BITS - 1);
    localparam logic [KW-1:0] K_MAX    = KW'(2 * OPERAND_BITS);

    mmi_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [KW-1:0]   k_reg, k_next;
    logic [1:0]      pass_reg, pass_next;
    logic            out_valid_reg, out_valid_next;
    logic            cnt_last;
    logic            out_free;
    logic            ami_done;

    assign cnt_last = (cnt_reg == CNT_LAST);
    assign out_free = !out_valid_reg || out_ready;
    assign ami_done = status.v_zero || (k_reg > K_MAX);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mmi_pkg::S_IDLE:   if (in_valid) state_next = mmi_pkg::S_CHECK;
            mmi_pkg::S_CHECK:  state_next = status.p_ok ? mmi_pkg::S_PREP : mmi_pkg::S_CLR;
            mmi_pkg::S_PREP:   if (cnt_last) state_next = mmi_pkg::S_R2;
            mmi_pkg::S_R2:     if (cnt_last) state_next = mmi_pkg::S_SETUP;
            mmi_pkg::S_SETUP:  state_next = mmi_pkg::S_ZCHK;
            mmi_pkg::S_ZCHK:   state_next = status.v_zero ? mmi_pkg::S_CLR : mmi_pkg::S_AMI;
            mmi_pkg::S_AMI:    if (ami_done) state_next = mmi_pkg::S_ACHK;
            mmi_pkg::S_ACHK:
                state_next = (status.v_zero && status.u_one) ? mmi_pkg::S_FIX
                                                             : mmi_pkg::S_CLR;
            mmi_pkg::S_FIX:    if (!status.r_ge_p) state_next = mmi_pkg::S_NEG;
            mmi_pkg::S_NEG:    state_next = mmi_pkg::S_HALF;
            mmi_pkg::S_HALF:   if (k_reg == '0) state_next = mmi_pkg::S_MSTART;
            mmi_pkg::S_MSTART: state_next = mmi_pkg::S_MSTEP;
            mmi_pkg::S_MSTEP:  if (cnt_last) state_next = mmi_pkg::S_MFIX;
            mmi_pkg::S_MFIX:
                if (pass_reg == 2'd0 || (pass_reg == 2'd1 && status.mode))
                    state_next = mmi_pkg::S_MSTART;
                else
                    state_next = mmi_pkg::S_OUT;
            mmi_pkg::S_CLR:    state_next = mmi_pkg::S_OUT;
            mmi_pkg::S_OUT:    if (out_free) state_next = mmi_pkg::S_IDLE;
            default:           state_next = mmi_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd            = '{op: mmi_pkg::OP_NONE, ysel: 1'b0, load_out: 1'b0};
        in_ready       = 1'b0;
        cnt_next       = '0;
        k_next         = k_reg;
        pass_next      = pass_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            mmi_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid) cmd.op = mmi_pkg::OP_LOAD;
            end
            mmi_pkg::S_PREP:
            begin
                cmd.op   = mmi_pkg::OP_REDUCE;
                cnt_next = cnt_last ? '0 : cnt_reg + 1'b1;
            end
            mmi_pkg::S_R2:
            begin
                cmd.op   = mmi_pkg::OP_R2;
                cnt_next = cnt_last ? '0 : cnt_reg + 1'b1;
            end
            mmi_pkg::S_SETUP:
            begin
                cmd.op    = mmi_pkg::OP_SETUP;
                k_next    = '0;
                pass_next = 2'd0;
            end
            mmi_pkg::S_AMI:
            begin
                if (!ami_done)
                begin
                    cmd.op = mmi_pkg::OP_AMI;
                    k_next = k_reg + 1'b1;
                end
            end
            mmi_pkg::S_FIX:    if (status.r_ge_p) cmd.op = mmi_pkg::OP_FIX;
            mmi_pkg::S_NEG:    cmd.op = mmi_pkg::OP_NEG;
            mmi_pkg::S_HALF:
            begin
                if (k_reg != '0)
                begin
                    cmd.op = mmi_pkg::OP_HALF;
                    k_next = k_reg - 1'b1;
                end
            end
            mmi_pkg::S_MSTART: cmd.op = mmi_pkg::OP_MSTART;
            mmi_pkg::S_MSTEP:
            begin
                cmd.op   = mmi_pkg::OP_MSTEP;
                cmd.ysel = (pass_reg == 2'd2);
                cnt_next = cnt_last ? '0 : cnt_reg + 1'b1;
            end
            mmi_pkg::S_MFIX:
            begin
                cmd.op    = mmi_pkg::OP_MFIX;
                pass_next = pass_reg + 1'b1;
            end
            mmi_pkg::S_CLR:    cmd.op = mmi_pkg::OP_CLR;
            mmi_pkg::S_OUT:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default: cmd.op = mmi_pkg::OP_NONE;
        endcase
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mmi_pkg::S_IDLE;
            cnt_reg       <= '0;
            k_reg         <= '0;
            pass_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            k_reg         <= k_next;
            pass_reg      <= pass_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### rtl/core/mmi_dp.sv
// Datapath of the Montgomery modular inverse core: modulus registers, operand
// reduction, radix square, almost-inverse steps, halvings, Montgomery products.
// Depends on mmi_pkg.
module mmi_dp #(
    parameter int OPERAND_BITS = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [mmi_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [mmi_pkg::WORD_BITS-1:0]       cfg_data,
    input  logic                                in_mode,
    input  logic [mmi_pkg::FIELD_BITS-1:0]      in_a,
    input  logic [mmi_pkg::FIELD_BITS-1:0]      in_b,
    input  mmi_pkg::cmd_t                       cmd,
    output mmi_pkg::status_t                    status,
    output logic [mmi_pkg::FIELD_BITS-1:0]      result
);

    localparam int M  = OPERAND_BITS;
    localparam int FB = mmi_pkg::FIELD_BITS;

    logic [mmi_pkg::WORD_BITS-1:0] mod_word_reg [mmi_pkg::NUM_WORDS];
    logic [mmi_pkg::FIELD_BITS-1:0] p_full;

    logic [M-1:0]   p_reg, a_reg, b_reg, rsq_reg, u_reg, v_reg;
    logic [M+1:0]   r_reg, s_reg;
    logic           mode_reg;
    logic [mmi_pkg::FIELD_BITS-1:0] res_reg;

    logic [M:0]     red_a, red_b, dbl_rsq, sub_a, sub_b, sub_rsq;
    logic [M:0]     d_uv, d_vu;
    logic [M+1:0]   p_ext, r_sum, half_t, m_t1, m_t2, y_ext;
    logic [M-1:0]   x_sel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < mmi_pkg::NUM_WORDS; i++) mod_word_reg[i] <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mmi_pkg::CFG_MODULUS_WORD0: mod_word_reg[0] <= cfg_data;
                mmi_pkg::CFG_MODULUS_WORD1: mod_word_reg[1] <= cfg_data;
                mmi_pkg::CFG_MODULUS_WORD2: mod_word_reg[2] <= cfg_data;
                mmi_pkg::CFG_MODULUS_WORD3: mod_word_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    assign p_full = {mod_word_reg[3], mod_word_reg[2], mod_word_reg[1], mod_word_reg[0]};
    assign p_ext  = {2'b00, p_reg};

    // Shift-in reduction of a and b, doubling of the radix square.
    assign red_a   = {a_reg, u_reg[M-1]};
    assign red_b   = {b_reg, v_reg[M-1]};
    assign dbl_rsq = {rsq_reg, 1'b0};
    assign sub_a   = red_a - {1'b0, p_reg};
    assign sub_b   = red_b - {1'b0, p_reg};
    assign sub_rsq = dbl_rsq - {1'b0, p_reg};

    // Almost-inverse step: borrow of v-u marks u > v.
    assign d_uv  = {1'b0, u_reg} - {1'b0, v_reg};
    assign d_vu  = {1'b0, v_reg} - {1'b0, u_reg};
    assign r_sum = r_reg + s_reg;

    assign half_t = s_reg + (s_reg[0] ? p_ext : '0);

    assign y_ext = {2'b00, (cmd.ysel ? a_reg : rsq_reg)};
    assign m_t1  = s_reg + (u_reg[0] ? y_ext : '0);
    assign m_t2  = m_t1 + (m_t1[0] ? p_ext : '0);

    assign x_sel = mode_reg ? b_reg : a_reg;

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            mmi_pkg::OP_LOAD:
            begin
                p_reg    <= p_full[M-1:0];
                u_reg    <= in_a[M-1:0];
                v_reg    <= in_b[M-1:0];
                a_reg    <= '0;
                b_reg    <= '0;
                rsq_reg  <= M'(1);
                mode_reg <= in_mode;
            end
            mmi_pkg::OP_REDUCE:
            begin
                a_reg   <= sub_a[M]   ? red_a[M-1:0]   : sub_a[M-1:0];
                b_reg   <= sub_b[M]   ? red_b[M-1:0]   : sub_b[M-1:0];
                rsq_reg <= sub_rsq[M] ? dbl_rsq[M-1:0] : sub_rsq[M-1:0];
                u_reg   <= {u_reg[M-2:0], 1'b0};
                v_reg   <= {v_reg[M-2:0], 1'b0};
            end
            mmi_pkg::OP_R2:
                rsq_reg <= sub_rsq[M] ? dbl_rsq[M-1:0] : sub_rsq[M-1:0];
            mmi_pkg::OP_SETUP:
            begin
                u_reg <= p_reg;
                v_reg <= x_sel;
                r_reg <= '0;
                s_reg <= (M+2)'(1);
            end
            mmi_pkg::OP_AMI:
            begin
                if (!u_reg[0])
                begin
                    u_reg <= u_reg >> 1;
                    s_reg <= {s_reg[M:0], 1'b0};
                end
                else if (!v_reg[0])
                begin
                    v_reg <= v_reg >> 1;
                    r_reg <= {r_reg[M:0], 1'b0};
                end
                else if (d_vu[M])
                begin
                    u_reg <= d_uv[M:1];
                    r_reg <= r_sum;
                    s_reg <= {s_reg[M:0], 1'b0};
                end
                else
                begin
                    v_reg <= d_vu[M:1];
                    s_reg <= r_sum;
                    r_reg <= {r_reg[M:0], 1'b0};
                end
            end
            mmi_pkg::OP_FIX:    r_reg <= r_reg - p_ext;
            mmi_pkg::OP_NEG:    s_reg <= p_ext - r_reg;
            mmi_pkg::OP_HALF:   s_reg <= half_t >> 1;
            mmi_pkg::OP_MSTART:
            begin
                u_reg <= s_reg[M-1:0];
                s_reg <= '0;
            end
            mmi_pkg::OP_MSTEP:
            begin
                s_reg <= m_t2 >> 1;
                u_reg <= u_reg >> 1;
            end
            mmi_pkg::OP_MFIX:   if (s_reg >= p_ext) s_reg <= s_reg - p_ext;
            mmi_pkg::OP_CLR:    s_reg <= '0;
            default: ;
        endcase
        if (cmd.load_out)
            res_reg <= FB'(s_reg[M-1:0]);
    end

    assign result = res_reg;

    always_comb
    begin
        status.p_ok   = p_reg[0] && (p_reg >= M'(3));
        status.mode   = mode_reg;
        status.v_zero = (v_reg == '0);
        status.u_one  = (u_reg == M'(1));
        status.r_ge_p = (r_reg >= p_ext);
    end

endmodule

### rtl/core/mmi_checker.sv
// Port-level checks of the Montgomery modular inverse core, bound to the top.
// Depends on mmi_pkg and the channel interfaces.
module mmi_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [mmi_pkg::WORD_BITS-1:0] result_word0
);

    // One item at a time: no transfer in the cycle after one.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken twice in a row");

    // A result never shows up right after its item enters.
    a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !$rose(out_valid))
        else $error("result raised right after input transfer");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("output valid dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(result_word0))
        else $error("output payload changed while stalled");

endmodule

bind montgomery_modular_inverse_core mmi_checker u_mmi_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .result_word0 (out_ch.result_word0)
);

### test/tb_montgomery_modular_inverse_core.sv
// Self-checking testbench of montgomery_modular_inverse_core: field inversion and
// division over several odd, even and composite moduli under random handshake idling.
// Depends on mmi_pkg, mmi_in_if, mmi_out_if and the core itself.
module tb_montgomery_modular_inverse_core;

    localparam int M           = 256;
    localparam int WATCH_LIMIT = 60000;   // cycles without any transfer
    localparam int LONG_HOLD   = 12000;   // receiver hold-off in the pressure phase
    localparam int SETTLE      = 40;

    typedef bit [M-1:0]   field_t;
    typedef bit [319:0]   wide_t;         // headroom for r, s and sums

    typedef struct {
        bit     mode;
        field_t a;
        field_t b;
    } inv_item_t;

    logic clk;
    logic rst_n;
    logic                             cfg_we;
    logic [mmi_pkg::CFG_IDX_BITS-1:0] cfg_index;
    logic [mmi_pkg::WORD_BITS-1:0]    cfg_data;

    mmi_in_if  in_ch ();
    mmi_out_if out_ch ();

    montgomery_modular_inverse_core #(.OPERAND_BITS(M)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // Pending operand items, expected results, and the predictor's modulus copy.
    inv_item_t pending_ops[$];
    field_t    quotient_q[$];
    field_t    modulus_copy;

    int  send_idle_pct;
    int  recv_stall_pct;
    bit  long_hold_req;
    int  mismatch_count;
    int  quiet_cycles;

    //------------------------------------------------------------------
    // Predictor
    //------------------------------------------------------------------

    // Shift-subtract reduction of the low M bits of x modulo p.
    function automatic wide_t reduce_mod(input wide_t x, input wide_t p);
        wide_t r;
        r = 0;
        for (int i = M - 1; i >= 0; i--)
        begin
            r = (r << 1) + wide_t'(x[i]);
            if (r >= p)
                r = r - p;
        end
        return r;
    endfunction

    // Bit-serial Montgomery product x * y * 2^-M mod p.
    function automatic wide_t mont_product(input wide_t x, input wide_t y, input wide_t p);
        wide_t t;
        t = 0;
        for (int i = 0; i < M; i++)
        begin
            if (x[i])
                t = t + y;
            if (t[0])
                t = t + p;
            t = t >> 1;
        end
        if (t >= p)
            t = t - p;
        return t;
    endfunction

    // Almost Montgomery inverse, then strip 2^k by modular halvings.
    function automatic bit plain_inverse(input wide_t x, input wide_t p, output wide_t inv);
        wide_t u, v, r, s;
        int    k;
        u = p;
        v = x;
        r = 0;
        s = 1;
        k = 0;
        inv = 0;
        while (v != 0 && k <= 2 * M)
        begin
            if (!u[0])
            begin
                u = u >> 1;
                s = s << 1;
            end
            else if (!v[0])
            begin
                v = v >> 1;
                r = r << 1;
            end
            else if (u > v)
            begin
                u = (u - v) >> 1;
                r = r + s;
                s = s << 1;
            end
            else
            begin
                v = (v - u) >> 1;
                s = s + r;
                r = r << 1;
            end
            k++;
        end
        if (v != 0 || u != 1)
            return 1'b0;
        while (r >= p)
            r = r - p;
        r = p - r;
        for (int i = 0; i < k; i++)
        begin
            if (r[0])
                r = r + p;
            r = r >> 1;
        end
        inv = r;
        return 1'b1;
    endfunction

    function automatic field_t predict_quotient(input inv_item_t it, input field_t pm);
        wide_t p, a, b, x, r2, inv, y;
        p = pm;
        y = 0;
        if (p[0] && p >= 3)
        begin
            r2 = 1;
            for (int i = 0; i < 2 * M; i++)
            begin
                r2 = r2 << 1;
                if (r2 >= p)
                    r2 = r2 - p;
            end
            a = reduce_mod(wide_t'(it.a), p);
            b = reduce_mod(wide_t'(it.b), p);
            x = it.mode ? b : a;
            if (x != 0 && plain_inverse(x, p, inv))
            begin
                y = mont_product(inv, r2, p);
                y = mont_product(y, r2, p);
                if (it.mode)
                    y = mont_product(y, a, p);
            end
        end
        return y[M-1:0];
    endfunction

    //------------------------------------------------------------------
    // Stimulus helpers
    //------------------------------------------------------------------

    function automatic field_t rand_field();
        field_t v;
        for (int i = 0; i < M / 32; i++)
            v[i*32 +: 32] = $urandom;
        return v;
    endfunction

    // Mostly reduced operands, with zero, edge values and wide ones mixed in.
    function automatic field_t pick_operand(input field_t p);
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return field_t'($urandom_range(1, 20));
            2:       return p - 1;
            3:       return p + field_t'($urandom_range(0, 3));
            4:       return ~field_t'($urandom_range(0, 3));
            5:       return rand_field();
            default: return (p != 0) ? rand_field() % p : rand_field();
        endcase
    endfunction

    task automatic push_op(input bit mode, input field_t a, input field_t b);
        inv_item_t it;
        it.mode = mode;
        it.a    = a;
        it.b    = b;
        pending_ops.push_back(it);
    endtask

    task automatic push_random(input int n);
        for (int i = 0; i < n; i++)
            push_op(bit'($urandom_range(0, 1)), pick_operand(modulus_copy),
                    pick_operand(modulus_copy));
    endtask

    // Hold until every item is sent and every quotient has arrived.
    task automatic drain();
        while (pending_ops.size() != 0 || in_ch.valid || quotient_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Write all four modulus words while the core is idle.
    task automatic load_modulus(input field_t p);
        for (int i = 0; i < mmi_pkg::NUM_WORDS; i++)
        begin
            @(posedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= (i == 0) ? mmi_pkg::CFG_MODULUS_WORD0 :
                         (i == 1) ? mmi_pkg::CFG_MODULUS_WORD1 :
                         (i == 2) ? mmi_pkg::CFG_MODULUS_WORD2 : mmi_pkg::CFG_MODULUS_WORD3;
            cfg_data  <= p[i*mmi_pkg::WORD_BITS +: mmi_pkg::WORD_BITS];
        end
        @(posedge clk);
        cfg_we <= 1'b0;
        modulus_copy = p;
    endtask

    //------------------------------------------------------------------
    // Clock and reset
    //------------------------------------------------------------------

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    //------------------------------------------------------------------
    // Driver: offer the head of pending_ops, predict each transfer
    //------------------------------------------------------------------

    always @(posedge clk)
    begin
        bit taken;
        taken = in_ch.valid && in_ch.ready;
        if (taken)
        begin
            quotient_q.push_back(predict_quotient(pending_ops[0], modulus_copy));
            void'(pending_ops.pop_front());
        end
        // Only change the offer when the current one is gone or none is up.
        if (taken || !in_ch.valid)
        begin
            if (pending_ops.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                in_ch.valid   <= 1'b1;
                in_ch.mode    <= pending_ops[0].mode;
                in_ch.a_word0 <= pending_ops[0].a[63:0];
                in_ch.a_word1 <= pending_ops[0].a[127:64];
                in_ch.a_word2 <= pending_ops[0].a[191:128];
                in_ch.a_word3 <= pending_ops[0].a[255:192];
                in_ch.b_word0 <= pending_ops[0].b[63:0];
                in_ch.b_word1 <= pending_ops[0].b[127:64];
                in_ch.b_word2 <= pending_ops[0].b[191:128];
                in_ch.b_word3 <= pending_ops[0].b[255:192];
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    //------------------------------------------------------------------
    // Monitor: stall at random, check each result transfer
    //------------------------------------------------------------------

    int hold_count = 0;
    bit hold_done  = 0;

    always @(posedge clk)
    begin
        field_t got, want;
        if (out_ch.valid && out_ch.ready)
        begin
            got = {out_ch.result_word3, out_ch.result_word2,
                   out_ch.result_word1, out_ch.result_word0};
            if (quotient_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result %h", got);
            end
            else
            begin
                want = quotient_q.pop_front();
                for (int w = 0; w < mmi_pkg::NUM_WORDS; w++)
                    if (got[w*64 +: 64] !== want[w*64 +: 64])
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("result_word%0d: expected %h got %h", w,
                                     want[w*64 +: 64], got[w*64 +: 64]);
                    end
            end
        end
        // Long hold-off: the core fills its output register and stalls input.
        if (long_hold_req && !hold_done)
        begin
            hold_count++;
            if (hold_count >= LONG_HOLD)
                hold_done = 1;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    //------------------------------------------------------------------
    // Watchdog
    //------------------------------------------------------------------

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCH_LIMIT)
        begin
            $display("** montgomery_modular_inverse_core: FAILED **");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    //------------------------------------------------------------------
    // Test sequence
    //------------------------------------------------------------------

    initial
    begin
        field_t p;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = mmi_pkg::CFG_MODULUS_WORD0;
        cfg_data       = '0;
        in_ch.valid    = 1'b0;
        in_ch.mode     = 1'b0;
        in_ch.a_word0  = '0;
        in_ch.a_word1  = '0;
        in_ch.a_word2  = '0;
        in_ch.a_word3  = '0;
        in_ch.b_word0  = '0;
        in_ch.b_word1  = '0;
        in_ch.b_word2  = '0;
        in_ch.b_word3  = '0;
        out_ch.ready   = 1'b0;
        modulus_copy   = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        long_hold_req  = 0;
        mismatch_count = 0;
        quiet_cycles   = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (5) @(posedge clk);

        // Items before any modulus write: reset modulus is zero, so results are zero.
        push_op(1'b0, field_t'(5), '0);
        push_op(1'b1, field_t'(7), field_t'(3));
        drain();

        // Phase 1: secp256k1 field prime, no idling, directed edge cases first.
        p = 256'hFFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFE_FFFFFC2F;
        load_modulus(p);
        push_op(1'b0, '0, '0);                   // zero operand
        push_op(1'b1, '0, field_t'(9));          // zero dividend
        push_op(1'b1, field_t'(9), '0);          // zero divisor
        push_op(1'b0, field_t'(1), '0);
        push_op(1'b0, field_t'(2), '0);
        push_op(1'b0, p - 1, '0);
        push_op(1'b0, p, '0);                    // reduces to zero
        push_op(1'b0, p + 1, '0);                // operand above modulus
        push_op(1'b0, '1, '1);                   // all ones
        push_op(1'b1, '1, '1);
        push_op(1'b1, p - 1, p - 1);
        push_op(1'b1, field_t'(1), p + 2);
        push_op(1'b1, rand_field(), field_t'(1));
        push_random(70);
        drain();

        // Phase 2: NIST P-256 prime, sender idle about half the time.
        p = 256'hFFFFFFFF_00000001_00000000_00000000_00000000_FFFFFFFF_FFFFFFFF_FFFFFFFF;
        load_modulus(p);
        send_idle_pct = 51;
        push_random(70);
        drain();

        // Phase 3: 2^255 - 19, receiver stalling about half the time.
        p = {1'b0, {250{1'b1}}, 5'b01101};
        load_modulus(p);
        send_idle_pct  = 0;
        recv_stall_pct = 51;
        push_random(70);
        drain();

        // Phase 4: the phase 1 prime again with a long receiver hold-off,
        // then light idling on both sides.
        p = 256'hFFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFE_FFFFFC2F;
        load_modulus(p);
        send_idle_pct  = 10;
        recv_stall_pct = 10;
        long_hold_req  = 1;
        push_random(60);
        drain();
        long_hold_req  = 0;

        // Phase 5: smallest valid modulus.
        load_modulus(field_t'(3));
        push_op(1'b0, '1, '1);
        push_op(1'b1, field_t'(2), field_t'(4));
        push_random(30);
        drain();

        // Phase 6: all-ones modulus (odd, composite): many operands have no inverse.
        load_modulus('1);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        push_op(1'b0, field_t'(3), '0);
        push_op(1'b0, field_t'(2), '0);
        push_random(30);
        drain();

        // Phase 7: bad moduli, even and below three, then a small composite.
        load_modulus({1'b1, {255{1'b0}}});
        push_random(10);
        drain();
        load_modulus(field_t'(1));
        push_random(8);
        drain();
        load_modulus(field_t'(15));
        push_random(25);
        drain();

        repeat (SETTLE) @(posedge clk);
        if (mismatch_count == 0 && quotient_q.size() == 0)
            $display("** montgomery_modular_inverse_core: PASSED **");
        else
            $display("** montgomery_modular_inverse_core: FAILED **");
        $finish;
    end

endmodule
